[rtl/core/tor_pkg.sv]
// Shared types, telnet codes and constant tables for the telnet option responder.
package tor_pkg;

    typedef logic [7:0] tn_byte_t;

    localparam int LINE_SPEED_W = 24;
    localparam int TABLE_DEPTH  = 256;
    localparam int NAME_LEN     = 5;
    localparam int POW_W        = 34;

    localparam logic [LINE_SPEED_W-1:0] LINE_SPEED_RESET = 24'd9600;

    localparam tn_byte_t TN_IAC  = 8'd255;
    localparam tn_byte_t TN_SB   = 8'd250;
    localparam tn_byte_t TN_SE   = 8'd240;
    localparam tn_byte_t TN_WILL = 8'd251;
    localparam tn_byte_t TN_WONT = 8'd252;
    localparam tn_byte_t TN_DO   = 8'd253;
    localparam tn_byte_t TN_DONT = 8'd254;
    localparam tn_byte_t TN_IS   = 8'd0;
    localparam tn_byte_t TN_SEND = 8'd1;
    localparam tn_byte_t TN_NONE = 8'd0;

    localparam tn_byte_t OPT_BINARY = 8'd0;
    localparam tn_byte_t OPT_TTYPE  = 8'd24;
    localparam tn_byte_t OPT_TSPEED = 8'd32;

    localparam tn_byte_t CHAR_ZERO  = 8'h30;
    localparam tn_byte_t CHAR_COMMA = 8'h2C;

    localparam logic REQ_VERB = 1'b0;
    localparam logic REQ_SUB  = 1'b1;

    localparam logic CFG_LINE_SPEED = 1'b0;
    localparam logic CFG_PARITY     = 1'b1;

    // Options that are always agreed to.
    function automatic logic always_agreed(input tn_byte_t opt);
        return opt inside {8'd1, 8'd3, 8'd24, 8'd31, 8'd32, 8'd35, 8'd36, 8'd39};
    endfunction

    // Options whose SEND subnegotiation is answered.
    function automatic logic sub_served(input tn_byte_t opt);
        return opt inside {8'd24, 8'd32, 8'd35, 8'd36, 8'd39};
    endfunction

    // Terminal name "VT100".
    function automatic tn_byte_t name_char(input logic [2:0] idx);
        tn_byte_t c;
        case (idx)
            3'd0: c = 8'h56;
            3'd1: c = 8'h54;
            3'd2: c = 8'h31;
            3'd3: c = 8'h30;
            3'd4: c = 8'h30;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [POW_W-1:0] pow10(input logic [3:0] n);
        logic [POW_W-1:0] p;
        case (n)
            4'd0: p = 34'd1;
            4'd1: p = 34'd10;
            4'd2: p = 34'd100;
            4'd3: p = 34'd1000;
            4'd4: p = 34'd10000;
            4'd5: p = 34'd100000;
            4'd6: p = 34'd1000000;
            4'd7: p = 34'd10000000;
            4'd8: p = 34'd100000000;
            4'd9: p = 34'd1000000000;
            4'd10: p = 34'd10000000000;
            default: p = 34'd0;
        endcase
        return p;
    endfunction

endpackage

[rtl/core/tor_ram.sv]
// Generic single-port-write, registered-read RAM.
module tor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/tor_dec.sv]
// Binary to decimal converter built on one shared compare-and-subtract unit.
module tor_dec #(
    parameter int DIGITS = 7,
    localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [tor_pkg::LINE_SPEED_W-1:0]  value,
    output logic                              done,
    output logic [POS_W-1:0]                  first,
    input  logic [POS_W-1:0]                  rd_pos,
    output logic [3:0]                        rd_digit
);

    import tor_pkg::*;

    localparam logic [POW_W-1:0] LIMIT    = pow10(4'(DIGITS)) - 34'd1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS - 1);
    localparam int               EXT_W    = POW_W - LINE_SPEED_W;

    logic                    busy_reg;
    logic                    done_reg;
    logic                    found_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [POS_W-1:0]        first_reg;
    logic [LINE_SPEED_W-1:0] rem_reg;
    logic [3:0]              dig_reg;
    logic [3:0]              digits_reg [DIGITS];

    logic [POW_W-1:0]        pow_cur;
    logic [POW_W-1:0]        rem_ext;
    logic [POW_W-1:0]        diff;
    logic                    ge;
    logic [LINE_SPEED_W-1:0] clamped;

    assign pow_cur = pow10(4'(pos_reg));
    assign rem_ext = {{EXT_W{1'b0}}, rem_reg};
    assign ge      = rem_ext >= pow_cur;
    assign diff    = rem_ext - pow_cur;
    assign clamped = ({{EXT_W{1'b0}}, value} > LIMIT) ? LIMIT[LINE_SPEED_W-1:0] : value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            pos_reg   <= LAST_POS;
            rem_reg   <= clamped;
            dig_reg   <= 4'd0;
            found_reg <= 1'b0;
            first_reg <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= diff[LINE_SPEED_W-1:0];
                dig_reg <= dig_reg + 4'd1;
            end else begin
                digits_reg[pos_reg] <= dig_reg;
                dig_reg             <= 4'd0;
                if (dig_reg != 4'd0 && !found_reg) begin
                    found_reg <= 1'b1;
                    first_reg <= pos_reg;
                end
                if (pos_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    pos_reg <= pos_reg - POS_W'(1);
                end
            end
        end
    end

    assign done     = done_reg;
    assign first    = first_reg;
    assign rd_digit = digits_reg[rd_pos];

endmodule

[rtl/core/telnet_option_responder_core.sv]
// Top level of the telnet option responder: request sequencer, option table and reply output.
//
// Requests arrive on the s_ channel, one transaction per request; the reply leaves on the
// m_ channel one byte per transaction, with m_tlast on the final byte of each reply.
// Configuration registers are written through cfg_wr_en, cfg_index and cfg_wdata; the user
// must write them only while the block is idle, which the block itself does not enforce;
// index 0 is the line speed and index 1 the parity flag. A negotiation request is accepted
// in ST_IDLE, looked up and updated in the option table in ST_EVAL and then answered with
// three reply bytes. A subnegotiation reply sends one byte per cycle while the receiver does
// not stall, up to 21 bytes. The speed reply also runs the decimal converter from acceptance,
// which works through the digit positions in turn on its one compare-and-subtract unit, and
// the reply waits for it before its digits. The next request is taken only once the last
// reply byte is in the output register. Requests that get no reply are dropped in the cycle
// they are accepted. After reset the option table is cleared one entry per cycle, all 256
// entries, with s_tready low; binary flags clear, line speed returns to 9600 and parity to off.
// When the receiver stalls, the current byte holds in the output register and the
// sequencer waits; a new request can be accepted while the last byte is still pending.
module telnet_option_responder_core #(
    parameter int SPEED_DIGITS = 7
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] verb, [15:8] option_code, [23:16] sub_code, [24] terminated
    input  logic [31:0]                      s_tdata,
    // [0] req_type
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] out_byte, [8] tx_binary_mode, [9] rx_binary_mode
    output logic [15:0]                      m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [tor_pkg::LINE_SPEED_W-1:0] cfg_wdata
);

    import tor_pkg::*;

    localparam int POS_W  = (SPEED_DIGITS > 1) ? $clog2(SPEED_DIGITS) : 1;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_EVAL, ST_WAIT,
        E_IAC, E_VERB, E_OPT, E_SB, E_IS, E_NAME,
        E_DIG1, E_COMMA, E_DIG2, E_IAC2, E_SE
    } state_t;

    state_t                  state_reg;
    logic [ADDR_W-1:0]       clr_cnt_reg;
    logic                    req_reg;
    tn_byte_t                verb_reg;
    tn_byte_t                opt_reg;
    tn_byte_t                rv_reg;
    logic [2:0]              name_cnt_reg;
    logic [POS_W-1:0]        dig_idx_reg;
    logic                    xmit_reg;
    logic                    recv_reg;
    logic [LINE_SPEED_W-1:0] line_speed_reg;
    logic                    parity_reg;
    logic                    m_tvalid_reg;
    tn_byte_t                m_byte_reg;
    logic                    m_last_reg;
    logic                    m_xmit_reg;
    logic                    m_recv_reg;

    logic                    accept;
    logic                    in_req;
    tn_byte_t                in_verb;
    tn_byte_t                in_opt;
    tn_byte_t                in_sub;
    logic                    in_term;
    logic                    dec_start;
    logic                    dec_done;
    logic [POS_W-1:0]        dec_first;
    logic [3:0]              dec_digit;
    tn_byte_t                tbl_rd_data;
    logic                    tbl_wr_en;
    logic [ADDR_W-1:0]       tbl_wr_addr;
    tn_byte_t                tbl_wr_data;
    tn_byte_t                rv_next;
    logic                    xmit_next;
    logic                    recv_next;
    logic                    agree;
    logic                    out_free;
    logic                    emit_ok;
    tn_byte_t                emit_byte;
    logic                    emit_last;

    assign in_verb  = s_tdata[7:0];
    assign in_opt   = s_tdata[15:8];
    assign in_sub   = s_tdata[23:16];
    assign in_term  = s_tdata[24];
    assign in_req   = s_tuser;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign dec_start = accept && (in_req == REQ_SUB) && (in_opt == OPT_TSPEED);

    tor_dec #(
        .DIGITS(SPEED_DIGITS)
    ) u_dec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dec_start),
        .value    (line_speed_reg),
        .done     (dec_done),
        .first    (dec_first),
        .rd_pos   (dig_idx_reg),
        .rd_digit (dec_digit)
    );

    tor_ram #(
        .WIDTH(8),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (in_opt),
        .rd_data (tbl_rd_data)
    );

    always_comb begin
        agree     = 1'b0;
        xmit_next = xmit_reg;
        recv_next = recv_reg;
        if (opt_reg == OPT_BINARY) begin
            case (verb_reg)
                TN_DO: begin
                    agree = !parity_reg;
                    if (!parity_reg) begin
                        xmit_next = 1'b1;
                    end
                end
                TN_DONT: begin
                    agree     = 1'b1;
                    xmit_next = 1'b0;
                end
                TN_WILL: begin
                    agree = !parity_reg;
                    if (!parity_reg) begin
                        recv_next = 1'b1;
                    end
                end
                TN_WONT: begin
                    agree     = 1'b1;
                    recv_next = 1'b0;
                end
                default: agree = 1'b0;
            endcase
        end else begin
            agree = always_agreed(opt_reg);
        end
        case (verb_reg)
            TN_DO:   rv_next = agree ? TN_WILL : TN_WONT;
            TN_DONT: rv_next = TN_WONT;
            TN_WILL: rv_next = agree ? TN_DO : TN_DONT;
            TN_WONT: rv_next = TN_DONT;
            default: rv_next = TN_NONE;
        endcase
    end

    // Outside the clear after reset, table entries are only rewritten when the recorded reply verb actually changes.
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = clr_cnt_reg;
            tbl_wr_data = TN_NONE;
        end else begin
            tbl_wr_en   = (state_reg == ST_EVAL) && (tbl_rd_data != rv_next);
            tbl_wr_addr = opt_reg;
            tbl_wr_data = rv_next;
        end
    end

    always_comb begin
        emit_byte = TN_NONE;
        emit_last = 1'b0;
        emit_ok   = 1'b0;
        case (state_reg)
            E_IAC: begin
                emit_byte = TN_IAC;
                emit_ok   = out_free;
            end
            E_VERB: begin
                emit_byte = rv_reg;
                emit_ok   = out_free;
            end
            E_OPT: begin
                emit_byte = opt_reg;
                emit_last = (req_reg == REQ_VERB);
                emit_ok   = out_free;
            end
            E_SB: begin
                emit_byte = TN_SB;
                emit_ok   = out_free;
            end
            E_IS: begin
                emit_byte = TN_IS;
                emit_ok   = out_free;
            end
            E_NAME: begin
                emit_byte = name_char(name_cnt_reg);
                emit_ok   = out_free;
            end
            E_DIG1, E_DIG2: begin
                emit_byte = CHAR_ZERO + {4'd0, dec_digit};
                emit_ok   = out_free;
            end
            E_COMMA: begin
                emit_byte = CHAR_COMMA;
                emit_ok   = out_free;
            end
            E_IAC2: begin
                emit_byte = TN_IAC;
                emit_ok   = out_free;
            end
            E_SE: begin
                emit_byte = TN_SE;
                emit_last = 1'b1;
                emit_ok   = out_free;
            end
            default: emit_ok = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            xmit_reg       <= 1'b0;
            recv_reg       <= 1'b0;
            line_speed_reg <= LINE_SPEED_RESET;
            parity_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_LINE_SPEED: line_speed_reg <= cfg_wdata;
                    CFG_PARITY:     parity_reg     <= cfg_wdata[0];
                    default:        parity_reg     <= parity_reg;
                endcase
            end

            if (emit_ok) begin
                m_tvalid_reg <= 1'b1;
                m_byte_reg   <= emit_byte;
                m_last_reg   <= emit_last;
                m_xmit_reg   <= xmit_reg;
                m_recv_reg   <= recv_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        req_reg  <= in_req;
                        verb_reg <= in_verb;
                        opt_reg  <= in_opt;
                        if (in_req == REQ_VERB) begin
                            state_reg <= ST_EVAL;
                        end else if (in_term && in_sub == TN_SEND && sub_served(in_opt)) begin
                            state_reg <= E_IAC;
                        end
                    end
                end
                ST_EVAL: begin
                    rv_reg    <= rv_next;
                    xmit_reg  <= xmit_next;
                    recv_reg  <= recv_next;
                    state_reg <= E_IAC;
                end
                ST_WAIT: begin
                    if (dec_done) begin
                        dig_idx_reg <= dec_first;
                        state_reg   <= E_DIG1;
                    end
                end
                E_IAC: begin
                    if (emit_ok) begin
                        state_reg <= (req_reg == REQ_VERB) ? E_VERB : E_SB;
                    end
                end
                E_VERB: begin
                    if (emit_ok) begin
                        state_reg <= E_OPT;
                    end
                end
                E_SB: begin
                    if (emit_ok) begin
                        state_reg <= E_OPT;
                    end
                end
                E_OPT: begin
                    if (emit_ok) begin
                        state_reg <= (req_reg == REQ_VERB) ? ST_IDLE : E_IS;
                    end
                end
                E_IS: begin
                    if (emit_ok) begin
                        name_cnt_reg <= 3'd0;
                        if (opt_reg == OPT_TTYPE) begin
                            state_reg <= E_NAME;
                        end else if (opt_reg == OPT_TSPEED) begin
                            state_reg <= ST_WAIT;
                        end else begin
                            state_reg <= E_IAC2;
                        end
                    end
                end
                E_NAME: begin
                    if (emit_ok) begin
                        name_cnt_reg <= name_cnt_reg + 3'd1;
                        if (name_cnt_reg == 3'(NAME_LEN - 1)) begin
                            state_reg <= E_IAC2;
                        end
                    end
                end
                E_DIG1: begin
                    if (emit_ok) begin
                        if (dig_idx_reg == '0) begin
                            state_reg <= E_COMMA;
                        end else begin
                            dig_idx_reg <= dig_idx_reg - POS_W'(1);
                        end
                    end
                end
                E_COMMA: begin
                    if (emit_ok) begin
                        dig_idx_reg <= dec_first;
                        state_reg   <= E_DIG2;
                    end
                end
                E_DIG2: begin
                    if (emit_ok) begin
                        if (dig_idx_reg == '0) begin
                            state_reg <= E_IAC2;
                        end else begin
                            dig_idx_reg <= dig_idx_reg - POS_W'(1);
                        end
                    end
                end
                E_IAC2: begin
                    if (emit_ok) begin
                        state_reg <= E_SE;
                    end
                end
                E_SE: begin
                    if (emit_ok) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'd0, m_recv_reg, m_xmit_reg, m_byte_reg};

endmodule
